// ----- design/ensh_pkg.sv -----
// Shared constants, types and a helper function for the edge suppression core.
package ensh_pkg;

   localparam int MaxWidth  = 1024;
   localparam int ColW      = $clog2(MaxWidth);
   localparam int MagW      = 15;
   localparam int AngW      = 12;
   localparam int CfgIdxW   = 2;
   localparam int CfgDataW  = 15;
   localparam int ImgWidthW = 11;

   localparam logic [CfgIdxW-1:0] CSR_HIGH_THR  = 2'd0;
   localparam logic [CfgIdxW-1:0] CSR_LOW_THR   = 2'd1;
   localparam logic [CfgIdxW-1:0] CSR_IMG_WIDTH = 2'd2;

   localparam logic [MagW-1:0]      HIGH_THR_RESET  = 15'd1600;
   localparam logic [MagW-1:0]      LOW_THR_RESET   = 15'd480;
   localparam logic [ImgWidthW-1:0] IMG_WIDTH_RESET = 11'd640;

   localparam logic [7:0] EDGE_ON  = 8'd255;
   localparam logic [7:0] EDGE_OFF = 8'd0;

   typedef enum logic [1:0] {
      SEC_HORIZ = 2'd0,
      SEC_DIAG_DOWN = 2'd1,
      SEC_VERT = 2'd2,
      SEC_DIAG_UP = 2'd3
   } sector_type;

   typedef logic [MagW-1:0] mag_type;
   typedef logic [ColW-1:0] col_type;

   // Per-pixel control that travels from the suppression stage to hysteresis.
   typedef struct packed {
      logic    go;      // stage-one result present
      col_type col;     // column of the transaction that carries the stage-one result
      logic    a_ok;    // middle row valid
      logic    b_ok;    // top row valid
      logic    emit;    // result leaves the block
   } nms_ctl_type;

   function automatic sector_type sector_of(input logic [AngW-1:0] ang);
      logic [AngW-1:0] a;
      a = ang;
      if (a > AngW'(2880))      a = a - AngW'(2880);
      else if (a > AngW'(1440)) a = a - AngW'(1440);
      if (a <= AngW'(180) || a >= AngW'(1260)) return SEC_HORIZ;
      else if (a <= AngW'(540))                return SEC_DIAG_DOWN;
      else if (a <= AngW'(900))                return SEC_VERT;
      else                                     return SEC_DIAG_UP;
   endfunction

endpackage

// ----- design/ensh_if.sv -----
// Valid/ready channel interfaces for pixel input, edge output and register writes.
interface ensh_req_if import ensh_pkg::*; ();
   logic          valid;
   logic          ready;
   logic [MagW-1:0] magnitude;
   logic [AngW-1:0] angle;
   logic          is_pad;
   logic          start_of_frame;
   modport source (output valid, magnitude, angle, is_pad, start_of_frame, input ready);
   modport sink   (input valid, magnitude, angle, is_pad, start_of_frame, output ready);
endinterface

interface ensh_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] edge_value;
   modport source (output valid, edge_value, input ready);
   modport sink   (input valid, edge_value, output ready);
endinterface

interface ensh_csr_if import ensh_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CfgIdxW-1:0]  index;
   logic [CfgDataW-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/ensh_nms.sv -----
// Non-maximum suppression stage: magnitude/sector line memories and 3x3 window.
module ensh_nms import ensh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  col_type     col,
   input  logic [1:0]  rows,
   input  mag_type     mag,
   input  sector_type  sec,
   output mag_type     sup_value,
   output nms_ctl_type sup_ctl
);
   // two rows of magnitude, rows selected by address msb
   mag_type    mag_mem [2*MaxWidth];
   logic [1:0] sec_mem [MaxWidth];

   mag_type    rd_a_ff, rd_b_ff;
   logic [1:0] rd_sec_ff;
   mag_type    m_ff;
   col_type    c_ff;
   logic [1:0] rs_ff;
   logic       v_ff;

   mag_type    win_ff [3][3];
   mag_type    win_in [3][3];
   logic [1:0] held_ff, held_in;
   logic [1:0] csec_in;
   mag_type    a, b;
   mag_type    res_ff, res_in, n1, n2, ctr;
   nms_ctl_type ctl_ff, ctl_in;

   // The read registers both rows at the column; the write-back of the same entries
   // happens when v_ff is set. Consecutive transactions use different columns, and
   // a column repeats only after a full row of transactions, so no overlap.
   always_ff @(posedge clock) begin
      if (step) begin
         rd_a_ff   <= mag_mem[{1'b0, col}];
         rd_b_ff   <= mag_mem[{1'b1, col}];
         rd_sec_ff <= sec_mem[col];
         m_ff      <= mag;
         c_ff      <= col;
         rs_ff     <= rows;
      end
      if (v_ff) begin
         mag_mem[{1'b1, c_ff}] <= a;
         mag_mem[{1'b0, c_ff}] <= m_ff;
         sec_mem[c_ff]         <= csec_in;
      end
   end

   // csec_in here stands for the sector written back (the current pixel's)
   logic [1:0] sec_d_ff;
   always_ff @(posedge clock) begin
      if (step) sec_d_ff <= sec;
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else       v_ff <= step;
   end

   assign a = (rs_ff >= 2'd1) ? rd_a_ff : '0;
   assign b = (rs_ff >= 2'd2) ? rd_b_ff : '0;

   always_comb begin
      win_in  = win_ff;
      held_in = held_ff;
      csec_in = sec_d_ff;
      res_in  = res_ff;
      ctl_in  = ctl_ff;
      ctl_in.go = 1'b0;
      n1 = '0;
      n2 = '0;
      ctr = '0;
      if (v_ff) begin
         held_in = rd_sec_ff;
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = (c_ff != '0) ? b    : '0;
         win_in[1][2] = (c_ff != '0) ? a    : '0;
         win_in[2][2] = (c_ff != '0) ? m_ff : '0;
         ctr = win_in[1][1];
         case (held_ff)
            SEC_HORIZ:     begin n1 = win_in[1][0]; n2 = win_in[1][2]; end
            SEC_DIAG_DOWN: begin n1 = win_in[0][0]; n2 = win_in[2][2]; end
            SEC_VERT:      begin n1 = win_in[0][1]; n2 = win_in[2][1]; end
            default:       begin n1 = win_in[0][2]; n2 = win_in[2][0]; end
         endcase
         res_in = (ctr < n1 || ctr < n2) ? '0 : ctr;
         ctl_in.go   = (c_ff != '0) ? (rs_ff >= 2'd1) : (rs_ff >= 2'd2);
         ctl_in.a_ok = (c_ff != '0) ? (rs_ff >= 2'd2) : (rs_ff == 2'd3);
         ctl_in.b_ok = (rs_ff == 2'd3);
         ctl_in.emit = (c_ff >= col_type'(2)) ? (rs_ff >= 2'd2) : (rs_ff == 2'd3);
         ctl_in.col  = c_ff;
         if (c_ff == '0) begin
            for (int r = 0; r < 3; r++) begin
               win_in[r][0] = '0;
               win_in[r][1] = '0;
            end
            win_in[0][2] = b;
            win_in[1][2] = a;
            win_in[2][2] = m_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
               win_ff[r][k] <= '0;
         held_ff <= '0;
         ctl_ff  <= '0;
      end else begin
         win_ff  <= win_in;
         held_ff <= held_in;
         ctl_ff  <= ctl_in;
      end
      res_ff <= res_in;
   end

   assign sup_value = res_ff;
   assign sup_ctl   = ctl_ff;
endmodule

// ----- design/ensh_hyst.sv -----
// Hysteresis stage: suppressed-value line memory, 3x3 window and double threshold.
module ensh_hyst import ensh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mag_type     sup_value,
   input  nms_ctl_type sup_ctl,
   input  col_type     last_col,
   input  mag_type     high_thr,
   input  mag_type     low_thr,
   output logic        out_valid,
   output logic [7:0]  out_edge
);
   mag_type sup_mem [2*MaxWidth];

   col_type c1;
   mag_type rd_a_ff, rd_b_ff, s_ff;
   col_type c1_ff;
   logic    a_ok_ff, b_ok_ff, emit_ff, v_ff;
   mag_type a2, b2;
   mag_type win_ff [3][3];
   mag_type win_in [3][3];
   logic    hi_nbr;
   logic [7:0] edge_in;

   // column of the pixel being suppressed this transaction
   assign c1 = (sup_ctl.col != '0) ? sup_ctl.col - col_type'(1) : last_col;

   always_ff @(posedge clock) begin
      if (sup_ctl.go) begin
         rd_a_ff <= sup_mem[{1'b0, c1}];
         rd_b_ff <= sup_mem[{1'b1, c1}];
         s_ff    <= sup_value;
         c1_ff   <= c1;
         a_ok_ff <= sup_ctl.a_ok;
         b_ok_ff <= sup_ctl.b_ok;
         emit_ff <= sup_ctl.emit;
      end
      if (v_ff) begin
         sup_mem[{1'b1, c1_ff}] <= a2;
         sup_mem[{1'b0, c1_ff}] <= s_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else       v_ff <= sup_ctl.go;
   end

   assign a2 = a_ok_ff ? rd_a_ff : '0;
   assign b2 = b_ok_ff ? rd_b_ff : '0;

   always_comb begin
      win_in  = win_ff;
      edge_in = EDGE_OFF;
      hi_nbr  = 1'b0;
      if (v_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = (c1_ff != '0) ? b2   : '0;
         win_in[1][2] = (c1_ff != '0) ? a2   : '0;
         win_in[2][2] = (c1_ff != '0) ? s_ff : '0;
         for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
               if ((r != 1 || k != 1) && win_in[r][k] > high_thr) hi_nbr = 1'b1;
         if (win_in[1][1] > high_thr)     edge_in = EDGE_ON;
         else if (win_in[1][1] < low_thr) edge_in = EDGE_OFF;
         else if (hi_nbr)                 edge_in = EDGE_ON;
         if (c1_ff == '0) begin
            for (int r = 0; r < 3; r++) begin
               win_in[r][0] = '0;
               win_in[r][1] = '0;
            end
            win_in[0][2] = b2;
            win_in[1][2] = a2;
            win_in[2][2] = s_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
               win_ff[r][k] <= '0;
      end else begin
         win_ff <= win_in;
      end
   end

   assign out_valid = v_ff && emit_ff;
   assign out_edge  = edge_in;
endmodule

// ----- design/edge_nonmax_suppress_hysteresis_core.sv -----
// Top level of the Canny back end: suppression and hysteresis on a pixel stream.
//
// req: raster pixels (magnitude, angle, is_pad, start_of_frame), valid/ready.
// rsp: one edge_value (255 or 0) per frame pixel, in raster order.
// csr: register writes (0 high threshold, 1 low threshold, 2 image width),
//      always accepted; write only while the block is idle.
// One pixel is taken per cycle while req_ready is high. The result for
// pixel p appears with the transaction of input p + 2*W + 2 (W the clamped
// width), so a frame needs 2*W + 2 pad transactions after its last pixel.
// Inside, each stage reads its line memory, then in the next cycle updates
// its window and writes back; the hysteresis result is written into an
// eight-entry output buffer, from which the receiver takes it.
// Reset clears control and windows; the line memories are not cleared,
// rows not yet filled in a frame are masked to zero.
// When the receiver stalls, req_ready stays high while the output buffer
// has room for everything in flight and drops otherwise; nothing is lost.
module edge_nonmax_suppress_hysteresis_core import ensh_pkg::*; (
   input logic         clock,
   input logic         reset,
   ensh_req_if.sink    req,
   ensh_rsp_if.source  rsp,
   ensh_csr_if.sink    csr
);
   localparam int FifoDepth = 8;
   localparam int PtrW = $clog2(FifoDepth);

   mag_type              high_ff, low_ff;
   logic [ImgWidthW-1:0] width_ff;
   col_type              col_ff, col_in, last_col;
   logic [1:0]           rows_ff, rows_in;
   col_type              col_cur;
   logic [1:0]           rows_cur;
   logic                 step, wrap;
   mag_type              m;
   sector_type           sec;
   mag_type              sup_value;
   nms_ctl_type          sup_ctl;
   logic                 hv;
   logic [7:0]           he;

   logic [7:0]  fifo_ff [FifoDepth];
   logic [PtrW-1:0] wp_ff, rp_ff;
   logic [PtrW:0]   cnt_ff;
   logic [2:0]      fly_ff;   // transactions in flight through the stages
   logic            pop;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff  <= HIGH_THR_RESET;
         low_ff   <= LOW_THR_RESET;
         width_ff <= IMG_WIDTH_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_HIGH_THR:  high_ff  <= csr.data;
            CSR_LOW_THR:   low_ff   <= csr.data;
            CSR_IMG_WIDTH: width_ff <= csr.data[ImgWidthW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff < ImgWidthW'(3))               last_col = col_type'(2);
      else if (width_ff > ImgWidthW'(MaxWidth))   last_col = col_type'(MaxWidth - 1);
      else last_col = col_type'(width_ff - ImgWidthW'(1));
   end

   // room for every in-flight transaction plus this one
   assign req.ready = ({1'b0, cnt_ff} + (PtrW+2)'(fly_ff)) < (PtrW+2)'(FifoDepth - 1);
   assign step = req.valid && req.ready;

   assign col_cur  = req.start_of_frame ? '0 : col_ff;
   assign rows_cur = req.start_of_frame ? '0 : rows_ff;
   assign wrap     = (col_cur >= last_col);
   assign m   = req.is_pad ? '0 : req.magnitude;
   assign sec = req.is_pad ? SEC_HORIZ : sector_of(req.angle);

   always_comb begin
      col_in  = col_ff;
      rows_in = rows_ff;
      if (step) begin
         if (wrap) begin
            col_in  = '0;
            rows_in = (rows_cur == 2'd3) ? rows_cur : rows_cur + 2'd1;
         end else begin
            col_in  = col_cur + col_type'(1);
            rows_in = rows_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         rows_ff <= '0;
      end else begin
         col_ff  <= col_in;
         rows_ff <= rows_in;
      end
   end

   ensh_nms u_nms (
      .clock(clock), .reset(reset), .step(step), .col(col_cur), .rows(rows_cur),
      .mag(m), .sec(sec), .sup_value(sup_value), .sup_ctl(sup_ctl)
   );

   ensh_hyst u_hyst (
      .clock(clock), .reset(reset), .sup_value(sup_value), .sup_ctl(sup_ctl),
      .last_col(last_col), .high_thr(high_ff), .low_thr(low_ff),
      .out_valid(hv), .out_edge(he)
   );

   // in-flight count: acceptances shifted through pipe_ff toward the hyst output
   logic [3:0] pipe_ff;
   always_ff @(posedge clock) begin
      if (reset) pipe_ff <= '0;
      else       pipe_ff <= {pipe_ff[2:0], step};
   end
   assign fly_ff = 3'($countones(pipe_ff));

   assign pop = rsp.valid && rsp.ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (hv)  wp_ff <= wp_ff + PtrW'(1);
         if (pop) rp_ff <= rp_ff + PtrW'(1);
         cnt_ff <= cnt_ff + (PtrW+1)'(hv) - (PtrW+1)'(pop);
      end
      if (hv) fifo_ff[wp_ff] <= he;
   end

   assign rsp.valid      = (cnt_ff != '0);
   assign rsp.edge_value = fifo_ff[rp_ff];
endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the Canny suppression and hysteresis core.
`timescale 1ns / 1ps

module tb_top;
   import ensh_pkg::*;

   typedef logic [8:0][MagW-1:0] win_type;   // 3x3 window, index row*3+col

   typedef struct packed {
      mag_type         mag;
      logic [AngW-1:0] ang;
      logic            pad;
      logic            sof;
   } pixel_type;

   localparam int StallLimit = 10000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ensh_req_if req_ch ();
   ensh_rsp_if rsp_ch ();
   ensh_csr_if csr_ch ();

   edge_nonmax_suppress_hysteresis_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   mag_type        high_thr, low_thr;
   logic [10:0]    width_reg;
   bit [MagW-1:0]  mag_rows [2*MaxWidth];
   bit [1:0]       sec_row  [MaxWidth];
   bit [MagW-1:0]  sup_rows [2*MaxWidth];
   win_type        mag_win, sup_win;
   sector_type     held_sec;
   int unsigned    col_pos, rows_seen;

   logic [7:0]     edge_q [$];
   int             mismatches = 0;
   int             n_sent = 0;
   int             tx_idle = 9, rx_idle = 70;
   int             stall_cycles = 0;
   pixel_type      directed [17];

   function automatic sector_type angle_sector(input logic [AngW-1:0] ang);
      int unsigned a;
      begin
         a = 32'(ang);
         if (a > 2880) a = a - 2880;
         else if (a > 1440) a = a - 1440;
         if (a <= 180 || a >= 1260) return SEC_HORIZ;
         if (a <= 540) return SEC_DIAG_DOWN;
         if (a <= 900) return SEC_VERT;
         return SEC_DIAG_UP;
      end
   endfunction

   function automatic win_type win_push(input win_type w, input mag_type top,
                                        input mag_type mid, input mag_type bot);
      win_type n;
      begin
         n = w;
         for (int r = 0; r < 3; r++) begin
            n[r*3]   = w[r*3+1];
            n[r*3+1] = w[r*3+2];
         end
         n[2] = top;
         n[5] = mid;
         n[8] = bot;
         return n;
      end
   endfunction

   function automatic logic [7:0] hysteresis(input win_type w);
      begin
         if (w[4] > high_thr) return EDGE_ON;
         if (w[4] < low_thr) return EDGE_OFF;
         for (int i = 0; i < 9; i++)
            if (i != 4 && w[i] > high_thr) return EDGE_ON;
         return EDGE_OFF;
      end
   endfunction

   // One pixel into the predictor; returns 1 when it yields an edge result.
   function automatic bit predict_edge(input pixel_type px, output logic [7:0] ev);
      int unsigned w, c, rs, c1;
      mag_type     m, a, b, s1, a2, b2, n1, n2;
      sector_type  sec, csec;
      bit          v1, v2, a2_ok;
      begin
         w = 32'(width_reg);
         if (w < 3) w = 3;
         if (w > MaxWidth) w = MaxWidth;
         if (px.sof) begin
            col_pos = 0;
            rows_seen = 0;
         end
         c = (col_pos >= MaxWidth) ? 0 : col_pos;
         rs = rows_seen;
         if (px.pad) begin
            m = '0;
            sec = SEC_HORIZ;
         end else begin
            m = px.mag;
            sec = angle_sector(px.ang);
         end
         a = (rs >= 1) ? mag_type'(mag_rows[c]) : '0;
         b = (rs >= 2) ? mag_type'(mag_rows[MaxWidth+c]) : '0;
         mag_rows[MaxWidth+c] = a;
         mag_rows[c] = m;
         csec = held_sec;
         held_sec = sector_type'(sec_row[c]);
         sec_row[c] = sec;
         mag_win = (c >= 1) ? win_push(mag_win, b, a, m) : win_push(mag_win, '0, '0, '0);
         case (csec)
            SEC_HORIZ:     begin n1 = mag_win[3]; n2 = mag_win[5]; end
            SEC_DIAG_DOWN: begin n1 = mag_win[0]; n2 = mag_win[8]; end
            SEC_VERT:      begin n1 = mag_win[1]; n2 = mag_win[7]; end
            default:       begin n1 = mag_win[2]; n2 = mag_win[6]; end
         endcase
         s1 = (mag_win[4] < n1 || mag_win[4] < n2) ? '0 : mag_win[4];
         v1 = (c >= 1) ? (rs >= 1) : (rs >= 2);
         if (c == 0) mag_win = win_push('0, b, a, m);
         v2 = 1'b0;
         ev = EDGE_OFF;
         if (v1) begin
            c1 = (c >= 1) ? c - 1 : w - 1;
            a2_ok = (c >= 1) ? (rs >= 2) : (rs >= 3);
            a2 = a2_ok ? mag_type'(sup_rows[c1]) : '0;
            b2 = (rs >= 3) ? mag_type'(sup_rows[MaxWidth+c1]) : '0;
            sup_rows[MaxWidth+c1] = a2;
            sup_rows[c1] = s1;
            sup_win = (c1 >= 1) ? win_push(sup_win, b2, a2, s1)
                                : win_push(sup_win, '0, '0, '0);
            ev = hysteresis(sup_win);
            v2 = (c >= 2) ? (rs >= 2) : (rs >= 3);
            if (c1 == 0) sup_win = win_push('0, b2, a2, s1);
         end
         if (c + 1 >= w) begin
            col_pos = 0;
            if (rows_seen < 3) rows_seen++;
         end else begin
            col_pos = c + 1;
         end
         return v2;
      end
   endfunction

   // result side: random back-pressure, checking and the watchdog
   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
         if (edge_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("edge mismatch: expected none actual %0d", rsp_ch.edge_value);
         end else if (rsp_ch.edge_value !== edge_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("edge mismatch: expected %0d actual %0d", edge_q[0], rsp_ch.edge_value);
            void'(edge_q.pop_front());
         end else begin
            void'(edge_q.pop_front());
         end
      end
      if (!reset) begin
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= StallLimit) begin
            $display("simulation failed");
            $finish;
         end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
   end

   task automatic send_pixel(input pixel_type px, input bit fixed_off);
      logic [7:0] ev;
      begin
         while ($urandom_range(0, 99) < tx_idle) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
         req_ch.valid          <= 1'b1;
         req_ch.magnitude      <= px.mag;
         req_ch.angle          <= px.ang;
         req_ch.is_pad         <= px.pad;
         req_ch.start_of_frame <= px.sof;
         do @(posedge clock); while (!req_ch.ready);
         n_sent++;
         if (predict_edge(px, ev)) edge_q.push_back(fixed_off ? EDGE_OFF : ev);
      end
   endtask

   // block must be idle: drain results, let trailing pads clear the pipe
   task automatic drain_results;
      begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while (edge_q.size() != 0) @(posedge clock);
         repeat (20) @(posedge clock);
      end
   endtask

   task automatic write_regs(input mag_type hi, input mag_type lo,
                             input logic [CfgDataW-1:0] wd);
      begin
         drain_results();
         csr_ch.valid <= 1'b1;
         csr_ch.index <= CSR_HIGH_THR;
         csr_ch.data  <= hi;
         do @(posedge clock); while (!csr_ch.ready);
         high_thr = hi;
         csr_ch.index <= CSR_LOW_THR;
         csr_ch.data  <= lo;
         do @(posedge clock); while (!csr_ch.ready);
         low_thr = lo;
         csr_ch.index <= CSR_IMG_WIDTH;
         csr_ch.data  <= wd;
         do @(posedge clock); while (!csr_ch.ready);
         width_reg = wd[10:0];
         csr_ch.valid <= 1'b0;
      end
   endtask

   function automatic mag_type pick_mag;
      int v;
      begin
         case ($urandom_range(0, 5))
            0, 1:    v = $urandom_range(0, 32767);
            2:       v = int'(high_thr) + $urandom_range(0, 16) - 8;
            3:       v = int'(low_thr) + $urandom_range(0, 16) - 8;
            4:       v = $urandom_range(0, 1) ? 32767 : 0;
            default: v = $urandom_range(0, 3000);
         endcase
         if (v < 0) v = 0;
         if (v > 32767) v = 32767;
         return mag_type'(v);
      end
   endfunction

   // frame of h rows at effective width w, then the drain pads (at times cut short);
   // a wide frame is cut to a short partial first row without pads
   task automatic send_frame(input int w, input int h);
      pixel_type px;
      int        npix;
      int        npad;
      begin
         npix = (w > 64) ? 48 : w * h;
         for (int i = 0; i < npix; i++) begin
            px.mag = pick_mag();
            px.ang = ($urandom_range(0, 9) == 0) ? AngW'($urandom_range(2880, 4095))
                                                 : AngW'($urandom_range(0, 2879));
            px.pad = 1'b0;
            px.sof = (i == 0) || ($urandom_range(0, 199) == 0);
            send_pixel(px, 1'b0);
         end
         npad = (w > 64) ? 0 : 2 * w + 2;
         if ($urandom_range(0, 9) == 0) npad = $urandom_range(0, npad);  // cut-short drain
         for (int i = 0; i < npad; i++) begin
            px.mag = MagW'($urandom_range(0, 32767));
            px.ang = AngW'($urandom_range(0, 4095));
            px.pad = 1'b1;
            px.sof = 1'b0;
            send_pixel(px, 1'b0);
         end
      end
   endtask

   task automatic run_phase(input mag_type hi, input mag_type lo,
                            input logic [CfgDataW-1:0] wd, input int frames);
      int w;
      begin
         write_regs(hi, lo, wd);
         w = int'(wd[10:0]);
         if (w < 3) w = 3;
         if (w > MaxWidth) w = MaxWidth;
         for (int f = 0; f < frames; f++) begin
            if (n_sent > 800) begin
               tx_idle = 0;
               rx_idle = 0;
            end else if (n_sent > 400) begin
               tx_idle = 70;
               rx_idle = 9;
            end
            send_frame(w, (w > 64) ? 2 : $urandom_range(1, 6));
         end
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.magnitude = '0;
      req_ch.angle = '0;
      req_ch.is_pad = 1'b0;
      req_ch.start_of_frame = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_HIGH_THR;
      csr_ch.data = '0;
      high_thr = HIGH_THR_RESET;
      low_thr = LOW_THR_RESET;
      width_reg = IMG_WIDTH_RESET;
      mag_win = '0;
      sup_win = '0;
      held_sec = SEC_HORIZ;
      col_pos = 0;
      rows_seen = 0;

      // 3x3 frame: sector boundaries, folding, out-of-range angles, extremes
      directed[0] = '{15'd32767, 12'd0,    1'b0, 1'b1};
      directed[1] = '{15'd0,     12'd181,  1'b0, 1'b0};
      directed[2] = '{15'd32767, 12'd541,  1'b0, 1'b0};
      directed[3] = '{15'd32767, 12'd901,  1'b0, 1'b0};
      directed[4] = '{15'd32767, 12'd1260, 1'b0, 1'b0};
      directed[5] = '{15'd21845, 12'd1441, 1'b0, 1'b0};
      directed[6] = '{15'd10922, 12'd2880, 1'b0, 1'b0};
      directed[7] = '{15'd32767, 12'd2881, 1'b0, 1'b0};
      directed[8] = '{15'd0,     12'd4095, 1'b0, 1'b0};
      for (int i = 9; i < 17; i++) directed[i] = '{15'd32767, 12'd2730, 1'b1, 1'b0};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // nothing can exceed a threshold at full scale: every result is off
      write_regs(15'd32767, 15'd32767, 15'd3);
      foreach (directed[i]) send_pixel(directed[i], 1'b1);

      run_phase(15'd1600, 15'd480, 15'd5, 3);
      run_phase(15'd0, 15'd0, 15'd3, 3);
      run_phase(15'd32767, 15'd0, 15'd4, 3);
      run_phase(15'd200, 15'd900, 15'd6, 3);      // low above high
      run_phase(15'd2000, 15'd1000, 15'd0, 3);    // width clamps up to 3
      run_phase(15'd1200, 15'd300, 15'h7FFF, 1);  // width clamps down to maximum
      run_phase(15'd32767, 15'd32767, 15'd7, 2);
      run_phase(15'd900, 15'd100, 15'd2, 3);
      while (n_sent < 1150)
         run_phase(mag_type'($urandom_range(0, 32767) >> $urandom_range(0, 4)),
                   mag_type'($urandom_range(0, 32767) >> $urandom_range(0, 5)),
                   CfgDataW'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767)
                                                         : $urandom_range(0, 12)), 3);
      run_phase(15'd800, 15'd100, 15'd1024, 1);

      drain_results();
      if (mismatches == 0 && edge_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- edge_nonmax_suppress_hysteresis_core.f -----
design/ensh_pkg.sv
design/ensh_if.sv
design/ensh_nms.sv
design/ensh_hyst.sv
design/edge_nonmax_suppress_hysteresis_core.sv
verif/tb_top.sv
